FILE: rtl/spq_pkg.sv
// Package for the stable priority queue: item word types, entry type,
// status and command codes, sizing constants. No dependencies.
package spq_pkg;

  localparam int DEPTH        = 16;
  localparam int PAYLOAD_BITS = 32;
  localparam int CNT_W        = $clog2(DEPTH + 1);

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_POP    = 1'b1;

  localparam logic [1:0] ST_INSERTED  = 2'd0;
  localparam logic [1:0] ST_POPPED    = 2'd1;
  localparam logic [1:0] ST_POP_EMPTY = 2'd2;
  localparam logic [1:0] ST_DROP_FULL = 2'd3;

  typedef struct packed {
    logic               command;
    logic signed [15:0] priority_req;
    logic [31:0]        payload;
  } in_word_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [15:0] out_priority;
    logic [31:0]        out_payload;
    logic [4:0]         occupancy;
  } out_word_t;

  typedef struct packed {
    logic signed [15:0]      prio;
    logic [PAYLOAD_BITS-1:0] pay;
  } entry_t;

  // Per-cycle operation broadcast to every cell.
  typedef struct packed {
    logic ins;
    logic pop;
  } cell_ctl_t;

endpackage

FILE: rtl/stable_priority_queue.sv
// Top level of the stable priority queue: entry count, chain of spq_cell
// slots and the result register. Depends on spq_pkg and spq_cell.
//
// Usage:
//   in channel  : in_valid / in_stall / in_word. command selects insert or
//                 pop; priority_req and payload matter for insert only.
//   out channel : out_valid / out_stall / out_word. Exactly one result word
//                 per input word, in order: status, popped priority and
//                 payload (zero unless popped), occupancy after the step.
//   Latency     : the result word appears the cycle after its input word
//                 is taken.
//   Throughput  : one word per cycle while in_stall is low. Every slot
//                 compares its priority with the new one in parallel and the
//                 chain shifts by one slot in the same cycle.
//   Reset       : rst_n low clears the count and the result valid; the
//                 queue starts empty. Slot contents are not cleared; only
//                 slots below the count are ever read.
//   Stall       : while out_stall holds a pending result, in_stall rises
//                 and the queue state holds until the result is taken.
//   Full/empty  : an insert into a full queue is dropped (status 3); a pop
//                 of an empty queue reports status 2.
module stable_priority_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  spq_pkg::in_word_t  in_word,
  output logic               out_valid,
  input  logic               out_stall,
  output spq_pkg::out_word_t out_word
);

  localparam int N = spq_pkg::DEPTH;

  logic [spq_pkg::CNT_W-1:0] count_r;
  logic [spq_pkg::CNT_W-1:0] count_nxt;
  logic                      out_valid_r;
  logic                      out_valid_nxt;
  spq_pkg::out_word_t        out_word_r;
  spq_pkg::out_word_t        out_word_nxt;

  logic               accept;
  logic               full;
  logic               empty;
  spq_pkg::cell_ctl_t ctl;
  spq_pkg::entry_t    new_entry;

  spq_pkg::entry_t cell_entry [N];
  logic            cell_keep  [N];

  // Hold the input while an untaken result sits in the output register.
  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;
  assign full     = (count_r == spq_pkg::CNT_W'(N));
  assign empty    = (count_r == '0);

  assign ctl.ins = accept && (in_word.command == spq_pkg::CMD_INSERT) && !full;
  assign ctl.pop = accept && (in_word.command == spq_pkg::CMD_POP) && !empty;

  assign new_entry.prio = in_word.priority_req;
  assign new_entry.pay  = in_word.payload[spq_pkg::PAYLOAD_BITS-1:0];

  // Chain of slots, head at index 0. Inserts shift right past the slots
  // that keep; pops shift everything left by one.
  for (genvar i = 0; i < N; i++) begin : g_cell
    logic            occ;
    logic            lkeep;
    spq_pkg::entry_t lent;
    spq_pkg::entry_t rent;

    assign occ = (spq_pkg::CNT_W'(i) < count_r);

    if (i == 0) begin : g_head
      assign lkeep = 1'b1;
      assign lent  = new_entry;
    end else begin : g_body
      assign lkeep = cell_keep[i-1];
      assign lent  = cell_entry[i-1];
    end

    if (i == N - 1) begin : g_tail
      assign rent = cell_entry[i];
    end else begin : g_inner
      assign rent = cell_entry[i+1];
    end

    spq_cell u_cell (
      .clk         (clk),
      .ctl         (ctl),
      .new_entry   (new_entry),
      .occupied    (occ),
      .left_keep   (lkeep),
      .left_entry  (lent),
      .right_entry (rent),
      .keep        (cell_keep[i]),
      .entry       (cell_entry[i])
    );
  end

  always_comb begin
    count_nxt = count_r;
    if (ctl.ins) begin
      count_nxt = count_r + 1'b1;
    end else if (ctl.pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  // Build the result word: status and popped entry from the state before this step, occupancy after it.
  always_comb begin
    out_word_nxt              = out_word_r;
    out_word_nxt.out_priority = '0;
    out_word_nxt.out_payload  = '0;
    if (in_word.command == spq_pkg::CMD_INSERT) begin
      out_word_nxt.status = full ? spq_pkg::ST_DROP_FULL : spq_pkg::ST_INSERTED;
    end else if (empty) begin
      out_word_nxt.status = spq_pkg::ST_POP_EMPTY;
    end else begin
      out_word_nxt.status       = spq_pkg::ST_POPPED;
      out_word_nxt.out_priority = cell_entry[0].prio;
      out_word_nxt.out_payload  = 32'(cell_entry[0].pay);
    end
    out_word_nxt.occupancy = 5'(count_nxt);
  end

  // Drop the valid once the result is taken, unless a new word arrives.
  assign out_valid_nxt = accept || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_word_r <= out_word_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

FILE: rtl/spq_cell.sv
// One slot of the sorted chain: holds an entry, keeps, takes the new entry
// or takes a neighbour's entry. Depends on spq_pkg.
module spq_cell (
  input  logic               clk,
  input  spq_pkg::cell_ctl_t ctl,
  input  spq_pkg::entry_t    new_entry,
  input  logic               occupied,
  input  logic               left_keep,
  input  spq_pkg::entry_t    left_entry,
  input  spq_pkg::entry_t    right_entry,
  output logic               keep,
  output spq_pkg::entry_t    entry
);

  spq_pkg::entry_t entry_r;
  spq_pkg::entry_t entry_nxt;

  // Stay in place when this slot is occupied and holds a priority not above the new one.
  assign keep  = occupied && (entry_r.prio <= new_entry.prio);
  assign entry = entry_r;

  always_comb begin
    entry_nxt = entry_r;
    priority if (ctl.ins) begin
      if (keep) begin
        entry_nxt = entry_r;
      end else if (left_keep) begin
        entry_nxt = new_entry;
      end else begin
        entry_nxt = left_entry;
      end
    end else if (ctl.pop) begin
      entry_nxt = right_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

FILE: rtl/spq_checker.sv
// Port-level checker for the stable priority queue, bound to the top level.
// Depends on spq_pkg.
module spq_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input spq_pkg::out_word_t out_word
);

  // A taken input word yields a result word in the next cycle.
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> out_valid)
    else $error("no result after accepted word");

  // A stalled result holds.
  a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_word)))
    else $error("stalled result changed");

  // Only a pop carries data.
  a_zero_unless_pop: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_word.status != spq_pkg::ST_POPPED)) |->
      ((out_word.out_priority == '0) && (out_word.out_payload == '0)))
    else $error("data on non-pop result");

  // Empty and full reports agree with the occupancy.
  a_empty_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |->
      (((out_word.status != spq_pkg::ST_POP_EMPTY) || (out_word.occupancy == '0)) &&
       ((out_word.status != spq_pkg::ST_DROP_FULL) ||
        (out_word.occupancy == 5'(spq_pkg::DEPTH)))))
    else $error("status disagrees with occupancy");

  // An insert always leaves at least one entry.
  a_insert_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_word.status == spq_pkg::ST_INSERTED)) |->
      (out_word.occupancy != '0))
    else $error("insert left queue empty");

endmodule

bind stable_priority_queue spq_checker u_spq_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_word  (out_word)
);

FILE: sim/tb.sv
// Self-checking testbench for stable_priority_queue: directed table, then random words
// under three idling phases, each result checked against a sorted-queue predictor or a
// typed row's result. Depends on spq_pkg and the RTL of stable_priority_queue.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD     = 20;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 8;
  localparam int RANDOM_WORDS   = 625;

  // One word waiting to be sent. Rows with typed set carry a hand-written result
  // that replaces the predictor's answer on the scoreboard.
  typedef struct packed {
    spq_pkg::in_word_t  word;
    logic               typed;
    spq_pkg::out_word_t want;
  } feed_word_t;

  // One row of the directed table; reps repeats the row with payload + k.
  typedef struct packed {
    spq_pkg::in_word_t  word;
    logic [4:0]         reps;
    logic               typed;
    spq_pkg::out_word_t want;
  } dir_row_t;

  // Directed part: empty pop, extreme priorities and payloads, a fill with runs of
  // equal priorities, an insert into the full queue, then pops of the oldest equals.
  localparam dir_row_t DIRECTED_ROWS [10] = '{
    '{'{spq_pkg::CMD_POP,    16'sd0,     32'h0000_0000}, 5'd1,  1'b1,
      '{spq_pkg::ST_POP_EMPTY, 16'sd0,     32'h0000_0000, 5'd0}},
    '{'{spq_pkg::CMD_INSERT, 16'sh7FFF,  32'hFFFF_FFFF}, 5'd1,  1'b1,
      '{spq_pkg::ST_INSERTED,  16'sd0,     32'h0000_0000, 5'd1}},
    '{'{spq_pkg::CMD_INSERT, 16'sh8000,  32'h0000_0000}, 5'd1,  1'b1,
      '{spq_pkg::ST_INSERTED,  16'sd0,     32'h0000_0000, 5'd2}},
    '{'{spq_pkg::CMD_POP,    16'sd0,     32'h0000_0000}, 5'd1,  1'b1,
      '{spq_pkg::ST_POPPED,    16'sh8000,  32'h0000_0000, 5'd1}},
    '{'{spq_pkg::CMD_POP,    16'sh1234,  32'h5555_AAAA}, 5'd1,  1'b1,
      '{spq_pkg::ST_POPPED,    16'sh7FFF,  32'hFFFF_FFFF, 5'd0}},
    '{'{spq_pkg::CMD_INSERT, 16'sd3,     32'h0000_0100}, 5'd6,  1'b0, '0},
    '{'{spq_pkg::CMD_INSERT, -16'sd5,    32'h0000_0200}, 5'd5,  1'b0, '0},
    '{'{spq_pkg::CMD_INSERT, 16'sd3,     32'h0000_0300}, 5'd5,  1'b0, '0},
    '{'{spq_pkg::CMD_INSERT, 16'sd0,     32'hDEAD_BEEF}, 5'd1,  1'b1,
      '{spq_pkg::ST_DROP_FULL, 16'sd0,     32'h0000_0000, 5'd16}},
    '{'{spq_pkg::CMD_POP,    16'sd0,     32'h0000_0000}, 5'd2,  1'b0, '0}
  };

  localparam logic signed [15:0] EDGE_PRIOS [4] = '{16'sh8000, 16'sh7FFF, 16'shFFFF, 16'sd0};

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  logic               in_stall;
  spq_pkg::in_word_t  in_word   = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  spq_pkg::out_word_t out_word;

  // Predictor state: held entries in leaving order, and their number.
  logic signed [15:0]               held_prio [spq_pkg::DEPTH];
  logic [spq_pkg::PAYLOAD_BITS-1:0] held_pay  [spq_pkg::DEPTH];
  int                               held_count = 0;

  feed_word_t         pending_words[$];
  spq_pkg::out_word_t awaited_results[$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int mismatch_count = 0;
  int stuck_cycles   = 0;

  stable_priority_queue i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Apply one accepted word to the predictor and return the result it must give.
  // An insert lands after every held entry of lower or equal priority, so equal
  // priorities leave in arrival order; a pop takes the head.
  function automatic spq_pkg::out_word_t sorted_queue_step(spq_pkg::in_word_t w);
    spq_pkg::out_word_t r;
    int slot;
    r = '0;
    if (w.command == spq_pkg::CMD_INSERT) begin
      if (held_count >= spq_pkg::DEPTH) begin
        r.status = spq_pkg::ST_DROP_FULL;
      end else begin
        slot = 0;
        while (slot < held_count && held_prio[slot] <= w.priority_req) slot++;
        for (int i = held_count; i > slot; i--) begin
          held_prio[i] = held_prio[i-1];
          held_pay[i]  = held_pay[i-1];
        end
        held_prio[slot] = w.priority_req;
        held_pay[slot]  = w.payload[spq_pkg::PAYLOAD_BITS-1:0];
        held_count++;
        r.status = spq_pkg::ST_INSERTED;
      end
    end else begin
      if (held_count == 0) begin
        r.status = spq_pkg::ST_POP_EMPTY;
      end else begin
        r.status       = spq_pkg::ST_POPPED;
        r.out_priority = held_prio[0];
        r.out_payload  = 32'(held_pay[0]);
        for (int i = 1; i < held_count; i++) begin
          held_prio[i-1] = held_prio[i];
          held_pay[i-1]  = held_pay[i];
        end
        held_count--;
      end
    end
    r.occupancy = 5'(held_count);
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("MISMATCH %s: got %0h want %0h at %0t", what, got, want, $realtime);
    mismatch_count++;
  endtask

  // Random words come in runs that lean towards inserting or popping, so the
  // queue swings between full and empty. Priorities mix the full range, the
  // extremes and a narrow band around zero that makes many equal keys.
  task automatic queue_random_words(input int count);
    feed_word_t entry;
    int run_left;
    bit filling;
    bit lean;
    run_left = 0;
    filling  = 1'b0;
    repeat (count) begin
      if (run_left == 0) begin
        filling  = !filling;
        run_left = $urandom_range(40, 6);
      end
      run_left--;
      lean = ($urandom_range(99) < 80);
      entry.word.command = (filling == lean) ? spq_pkg::CMD_INSERT : spq_pkg::CMD_POP;
      case ($urandom_range(3))
        0:       entry.word.priority_req = 16'($urandom);
        1:       entry.word.priority_req = EDGE_PRIOS[$urandom_range(3)];
        default: entry.word.priority_req = 16'($urandom_range(6) - 3);
      endcase
      entry.word.payload = $urandom;
      entry.typed        = 1'b0;
      entry.want         = '0;
      pending_words.push_back(entry);
    end
  endtask

  // Input side: on a taken word, advance the predictor and file the expected
  // result; then present the next word unless this cycle idles. Hold a word that
  // is stalled, unchanged.
  always @(posedge clk) begin : drive_words
    bit                 taken;
    spq_pkg::out_word_t predicted;
    taken = rst_n && in_valid && !in_stall;
    if (taken) begin
      predicted = sorted_queue_step(in_word);
      awaited_results.push_back(pending_words[0].typed ? pending_words[0].want : predicted);
      void'(pending_words.pop_front());
    end
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || taken) begin
      if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_word  <= pending_words[0].word;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result side: compare every taken word with the oldest expectation, field by
  // field, and stall at random for the next cycle.
  always @(posedge clk) begin : check_words
    spq_pkg::out_word_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (awaited_results.size() == 0) begin
          report_mismatch("result word with none awaited", 64'(out_word), '0);
        end else begin
          want = awaited_results.pop_front();
          if (out_word.status != want.status)
            report_mismatch("status", 64'(out_word.status), 64'(want.status));
          if (out_word.out_priority != want.out_priority)
            report_mismatch("out_priority", 64'(out_word.out_priority),
                            64'(want.out_priority));
          if (out_word.out_payload != want.out_payload)
            report_mismatch("out_payload", 64'(out_word.out_payload),
                            64'(want.out_payload));
          if (out_word.occupancy != want.occupancy)
            report_mismatch("occupancy", 64'(out_word.occupancy), 64'(want.occupancy));
        end
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Watchdog: end the run if neither channel moves a word for too long.
  always @(posedge clk) begin : watchdog
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
      stuck_cycles <= 0;
    else
      stuck_cycles <= stuck_cycles + 1;
    if (stuck_cycles >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin : run_phases
    feed_word_t entry;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Phase one: sender idles often, receiver stalls more often still.
    send_idle_pct  = 38;
    recv_stall_pct = 76;
    foreach (DIRECTED_ROWS[r]) begin
      for (int k = 0; k < int'(DIRECTED_ROWS[r].reps); k++) begin
        entry.word         = DIRECTED_ROWS[r].word;
        entry.word.payload = entry.word.payload + 32'(k);
        entry.typed        = DIRECTED_ROWS[r].typed;
        entry.want         = DIRECTED_ROWS[r].want;
        pending_words.push_back(entry);
      end
    end
    queue_random_words(RANDOM_WORDS);

    // Between phases hold the sender until every expected word has come back.
    for (int phase = 0; phase < 3; phase++) begin
      if (phase == 1) begin
        send_idle_pct  = 76;
        recv_stall_pct = 38;
        queue_random_words(RANDOM_WORDS);
      end else if (phase == 2) begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        queue_random_words(RANDOM_WORDS);
      end
      while (pending_words.size() != 0 || awaited_results.size() != 0) @(posedge clk);
    end

    // Let any stray word surface before judging the run.
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (awaited_results.size() != 0)
      report_mismatch("results never delivered", 64'(awaited_results.size()), '0);
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
